@@ rtl/cle_pkg.sv @@
package cle_pkg;

    localparam int MAX_LINE = 32;
    localparam int ADDR_W   = $clog2(MAX_LINE);
    localparam int CAP_W    = 6;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_LINE);

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       connected;
        logic [1:0] tx_free;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       status;
        logic [4:0] line_length;
        logic       last;
    } t_out;

    // echo sequences
    typedef enum logic [1:0] {
        SEQ_CRLF  = 2'd0,
        SEQ_ERASE = 2'd1,
        SEQ_CHAR  = 2'd2
    } t_seq;

    // what the output register is loaded with
    typedef enum logic [1:0] {
        EM_ECHO = 2'd0,
        EM_LINE = 2'd1,
        EM_OK   = 2'd2,
        EM_FAIL = 2'd3
    } t_emit;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECODE = 3'd1,
        ST_ECHO   = 3'd2,
        ST_RD     = 3'd3,
        ST_LINE   = 3'd4,
        ST_STAT   = 3'd5,
        ST_FAIL   = 3'd6
    } t_state;

    typedef struct packed {
        logic  load;
        logic  clr_swallow;
        logic  set_swallow;
        logic  wr_char;
        logic  dec_count;
        logic  clr_count;
        logic  seq_load;
        t_seq  seq;
        logic  idx_inc;
        logic  rd_start;
        logic  rd_issue;
        logic  rd_inc;
        logic  emit;
        t_emit emit_sel;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic conn;
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic is_print;
        logic swallow;
        logic count_zero;
        logic room;
        logic echo_refused;
        logic echo_end;
        logic seq_crlf;
        logic rd_done;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] echo_byte(t_seq seq, logic [1:0] idx, logic [7:0] b);
        logic [7:0] r;
        r = b;
        unique case (seq)
            SEQ_CRLF:  r = (idx == 2'd0) ? CH_CR : CH_LF;
            SEQ_ERASE: r = (idx == 2'd1) ? CH_SPACE : CH_BS;
            SEQ_CHAR:  r = b;
            default:   r = b;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] seq_last_idx(t_seq seq);
        logic [1:0] r;
        r = 2'd0;
        unique case (seq)
            SEQ_CRLF:  r = 2'd1;
            SEQ_ERASE: r = 2'd2;
            SEQ_CHAR:  r = 2'd0;
            default:   r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/cle_ctrl.sv @@
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cle_pkg::t_sts i_sts,
    output logic          o_ready,
    output cle_pkg::t_cmd o_cmd
);
    import cle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                priority if (!i_sts.conn) begin
                    n_state = ST_FAIL;
                end else if (i_sts.swallow && i_sts.is_lf) begin
                    n_state = ST_IDLE;
                end else if (i_sts.is_cr || i_sts.is_lf) begin
                    n_state = ST_ECHO;
                end else if (i_sts.is_bs) begin
                    n_state = i_sts.count_zero ? ST_IDLE : ST_ECHO;
                end else if (i_sts.is_print) begin
                    n_state = i_sts.room ? ST_ECHO : ST_IDLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ECHO: begin
                priority if (i_sts.echo_refused) begin
                    n_state = ST_FAIL;
                end else if (i_sts.out_free && i_sts.echo_end) begin
                    n_state = i_sts.seq_crlf ? ST_RD : ST_IDLE;
                end else begin
                    n_state = ST_ECHO;
                end
            end
            ST_RD: begin
                n_state = i_sts.rd_done ? ST_STAT : ST_LINE;
            end
            ST_LINE: begin
                if (i_sts.out_free) n_state = ST_RD;
            end
            ST_STAT, ST_FAIL: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                if (i_sts.conn) begin
                    o_cmd.clr_swallow = 1'b1;
                    priority if (i_sts.swallow && i_sts.is_lf) begin
                        o_cmd.clr_swallow = 1'b1;
                    end else if (i_sts.is_cr || i_sts.is_lf) begin
                        o_cmd.set_swallow = i_sts.is_cr;
                        o_cmd.seq_load    = 1'b1;
                        o_cmd.seq         = SEQ_CRLF;
                    end else if (i_sts.is_bs) begin
                        o_cmd.dec_count = !i_sts.count_zero;
                        o_cmd.seq_load  = 1'b1;
                        o_cmd.seq       = SEQ_ERASE;
                    end else if (i_sts.is_print) begin
                        o_cmd.wr_char  = i_sts.room;
                        o_cmd.seq_load = 1'b1;
                        o_cmd.seq      = SEQ_CHAR;
                    end else begin
                        o_cmd.clr_swallow = 1'b1;
                    end
                end
            end
            ST_ECHO: begin
                if (!i_sts.echo_refused && i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_ECHO;
                    o_cmd.emit_last = i_sts.echo_end && !i_sts.seq_crlf;
                    o_cmd.idx_inc   = !i_sts.echo_end;
                    o_cmd.rd_start  = i_sts.echo_end && i_sts.seq_crlf;
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = !i_sts.rd_done;
            end
            ST_LINE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_LINE;
                    o_cmd.rd_inc   = 1'b1;
                end
            end
            ST_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_OK;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clr_count = 1'b1;
                end
            end
            ST_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_FAIL;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clr_count = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/cle_dpath.sv @@
module cle_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [cle_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  cle_pkg::t_in              i_in_data,
    input  logic                      i_out_stall,
    input  cle_pkg::t_cmd             i_cmd,
    output cle_pkg::t_sts             o_sts,
    output logic                      o_out_valid,
    output cle_pkg::t_out             o_out_data
);
    import cle_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    t_in               r_in;
    logic [ADDR_W-1:0] r_count;
    logic              r_swallow;
    t_seq              r_seq;
    logic [1:0]        r_idx;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_store [MAX_LINE];
    t_out              r_out;
    logic              r_out_valid;

    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W-1:0]  count_next;
    logic [7:0]        b;
    t_out              n_out;

    assign b          = r_in.rx_byte;
    assign cap_eff    = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign count_next = CAP_W'(r_count) + CAP_W'(1);

    assign o_sts.conn         = r_in.connected;
    assign o_sts.is_cr        = (b == CH_CR);
    assign o_sts.is_lf        = (b == CH_LF);
    assign o_sts.is_bs        = (b == CH_BS) || (b == CH_DEL);
    assign o_sts.is_print     = (b >= CH_SPACE) && (b != CH_DEL);
    assign o_sts.swallow      = r_swallow;
    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.room         = (count_next < cap_eff);
    assign o_sts.echo_refused = (r_idx >= r_in.tx_free);
    assign o_sts.echo_end     = (r_idx == seq_last_idx(r_seq));
    assign o_sts.seq_crlf     = (r_seq == SEQ_CRLF);
    assign o_sts.rd_done      = (r_rd_idx == r_count);
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_swallow   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;

            if (i_cmd.set_swallow) begin
                r_swallow <= 1'b1;
            end else if (i_cmd.clr_swallow) begin
                r_swallow <= 1'b0;
            end

            priority if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.wr_char) begin
                r_count <= r_count + ADDR_W'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - ADDR_W'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        if (i_cmd.seq_load) begin
            r_seq <= i_cmd.seq;
            r_idx <= 2'd0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 2'd1;
        end
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_inc) begin
            r_rd_idx <= r_rd_idx + ADDR_W'(1);
        end
        if (i_cmd.emit) r_out <= n_out;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_char) r_store[r_count] <= b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) r_rd_data <= r_store[r_rd_idx];
    end

    always_comb begin
        n_out      = '0;
        n_out.last = i_cmd.emit_last;
        unique case (i_cmd.emit_sel)
            EM_ECHO: begin
                n_out.kind = KIND_ECHO;
                n_out.data = echo_byte(r_seq, r_idx, b);
            end
            EM_LINE: begin
                n_out.kind = KIND_LINE;
                n_out.data = r_rd_data;
            end
            EM_OK: begin
                n_out.kind        = KIND_STATUS;
                n_out.line_length = 5'(r_count);
            end
            EM_FAIL: begin
                n_out.kind   = KIND_STATUS;
                n_out.status = 1'b1;
            end
            default: begin
                n_out.kind = KIND_STATUS;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/console_line_editor_unit.sv @@
// console line editor: canonical-mode line editing with echo for a uart
// receive stream. one beat in carries a received byte, the terminal-present
// flag and the number of echo bytes the transmitter can take; it gives zero
// or more beats out (echo bytes, the stored line, a status beat), the final
// one flagged last. items are handled one at a time: the input stalls once
// an item is accepted until its last result beat is loaded into the output
// register, or until decode drops an item that gives no beat. a plain byte
// is decoded, then its echo bytes are loaded into the output register in
// turn; a line end is decoded and echoed as cr and lf, then each stored
// byte is read out (a registered read of the line store followed by the
// output load) and the status beat follows (the end-of-line read check,
// then the load). a full line holds 31 bytes.
// line_capacity is written through i_cfg_wr_en / i_cfg_wr_data and must
// only change while the block is idle; values above 32 act as 32
module console_line_editor_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [cle_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  cle_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cle_pkg::t_out             o_out_data
);
    import cle_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ready;

    // sequencer: decode, echo walk, line read-out, status
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    // input latch, line store, counters and the output register
    cle_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    // stall whenever an item is still in flight
    assign o_in_stall = !ready;

endmodule

@@ rtl/cle_checker.sv @@
module cle_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input cle_pkg::t_out o_out_data
);
    import cle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted back to back");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_STATUS |->
            o_out_data.last && o_out_data.data == 8'h00)
        else $error("status beat malformed");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_STATUS |->
            !o_out_data.status && o_out_data.line_length == 5'd0)
        else $error("data beat carries status fields");

    a_fail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.line_length == 5'd0)
        else $error("failed line reports a length");

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
